[sv/lcg_shuf_pkg.sv]
// ----------------------------------------------------------------------------
// lcg_shuf_pkg
// Shared constants, controller states and the command and status bundles of
// the shuffled minimal-standard random generator.
// ----------------------------------------------------------------------------
package lcg_shuf_pkg;

    localparam int VALUE_W = 31;

    localparam logic [14:0]        LCG_MULT       = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD        = 31'd2147483647;
    localparam logic [VALUE_W-1:0] NEAR_ONE_LIMIT = 31'd2147483389;
    localparam logic [VALUE_W-1:0] SEED_RESET     = 31'd50;
    localparam int                 WARMUP_STEPS   = 8;
    localparam int                 TABLE_DEPTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_FOLD,
        ST_DRAW_MUL,
        ST_DRAW_FOLD,
        ST_DRAW_WRITE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_seed;   // load generator from seed, arm the init counter
        logic mul;         // register generator and slot products
        logic fold;        // fold product into the generator value
        logic init_step;   // fold belongs to initialization (fill table)
        logic draw_write;  // retire a draw: swap table slot, load output
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_zero;   // no valid previous output yet
        logic cnt_zero;    // last initialization step
        logic out_free;    // output register can take a word this cycle
    } status_t;

endpackage

[sv/lcg_shuf_ctrl.sv]
// ----------------------------------------------------------------------------
// lcg_shuf_ctrl
// Sequencer for initialization and draws of the shuffled generator.
// ----------------------------------------------------------------------------
module lcg_shuf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_reseed,
    output logic                  in_ready,
    input  lcg_shuf_pkg::status_t sts,
    output lcg_shuf_pkg::cmd_t    cmd
);
    import lcg_shuf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   need_init;

    assign need_init = in_reseed || sts.last_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = need_init ? ST_INIT_MUL : ST_DRAW_FOLD;
                end
            end
            ST_INIT_MUL:  state_next = ST_INIT_FOLD;
            ST_INIT_FOLD: state_next = sts.cnt_zero ? ST_DRAW_MUL : ST_INIT_MUL;
            ST_DRAW_MUL:  state_next = ST_DRAW_FOLD;
            ST_DRAW_FOLD: state_next = ST_DRAW_WRITE;
            ST_DRAW_WRITE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                // draw product now, unless reseed or no prior output forces init
                if (in_valid) begin
                    cmd.load_seed = need_init;
                    cmd.mul       = !need_init;
                end
            end
            ST_INIT_MUL:  cmd.mul = 1'b1;
            ST_INIT_FOLD: begin
                cmd.fold      = 1'b1;
                cmd.init_step = 1'b1;
            end
            ST_DRAW_MUL:  cmd.mul  = 1'b1;
            ST_DRAW_FOLD: cmd.fold = 1'b1;
            ST_DRAW_WRITE: cmd.draw_write = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[sv/lcg_shuf_dp.sv]
// ----------------------------------------------------------------------------
// lcg_shuf_dp
// Generator, slot divider, shuffle memory and output register.
// ----------------------------------------------------------------------------
module lcg_shuf_dp #(
    parameter int TABLE_DEPTH = lcg_shuf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lcg_shuf_pkg::VALUE_W-1:0] cfg_wr_data,
    input  lcg_shuf_pkg::cmd_t               cmd,
    output lcg_shuf_pkg::status_t            sts,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [lcg_shuf_pkg::VALUE_W-1:0] out_value,
    output logic                             out_near_one
);
    import lcg_shuf_pkg::*;

    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int INIT_STEPS = TABLE_DEPTH + WARMUP_STEPS;
    localparam int CNT_W      = $clog2(INIT_STEPS);
    localparam int PROD_W     = VALUE_W + 15;
    localparam int SPROD_W    = 63;

    // slot = last / SLOT_W, done exactly as (last * RECIP) >> SHIFT
    localparam logic [63:0] SLOT_W =
        64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH);
    localparam int          SHIFT  = VALUE_W + $clog2(SLOT_W);
    localparam logic [31:0] RECIP  =
        32'(((64'd1 << SHIFT) + SLOT_W - 64'd1) / SLOT_W);

    logic [VALUE_W-1:0] seed_reg;
    logic [VALUE_W-1:0] lcg_value_reg;
    logic [VALUE_W-1:0] last_output_reg;
    logic [PROD_W-1:0]  lcg_prod_reg;
    logic [SPROD_W-1:0] slot_prod_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_near_one_reg;

    logic [VALUE_W-1:0] shuffle_mem [TABLE_DEPTH];

    logic [VALUE_W-1:0] seed_fixed;
    logic [VALUE_W:0]   fold_sum;
    logic [VALUE_W-1:0] fold_value;
    logic [SPROD_W-1:0] slot_quot;
    logic [ADDR_W-1:0]  slot;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic               out_free;

    assign seed_fixed = (seed_reg == '0 || seed_reg == LCG_MOD) ? VALUE_W'(1) : seed_reg;

    // Mersenne fold: 2^31 == 1 mod M
    assign fold_sum   = {1'b0, lcg_prod_reg[VALUE_W-1:0]}
                      + (VALUE_W+1)'(lcg_prod_reg[PROD_W-1:VALUE_W]);
    assign fold_value = (fold_sum >= {1'b0, LCG_MOD})
                      ? VALUE_W'(fold_sum - {1'b0, LCG_MOD})
                      : fold_sum[VALUE_W-1:0];

    assign slot_quot = slot_prod_reg >> SHIFT;
    assign slot = (slot_quot >= SPROD_W'(TABLE_DEPTH))
                ? ADDR_W'(TABLE_DEPTH - 1) : slot_quot[ADDR_W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot;
        mem_wr_data = lcg_value_reg;
        mem_rd_en   = cmd.fold && !cmd.init_step;
        if (cmd.fold && cmd.init_step && cnt_reg < CNT_W'(TABLE_DEPTH)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_reg[ADDR_W-1:0];
            mem_wr_data = fold_value;
        end else if (cmd.draw_write) begin
            mem_wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            shuffle_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= shuffle_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg        <= SEED_RESET;
            last_output_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            // the last fill step writes slot 0, which becomes the previous output
            if (cmd.fold && cmd.init_step && cnt_reg == '0) begin
                last_output_reg <= fold_value;
            end else if (cmd.draw_write) begin
                last_output_reg <= rd_data_reg;
            end
            if (cmd.draw_write) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_seed) begin
            lcg_value_reg <= seed_fixed;
            cnt_reg       <= CNT_W'(INIT_STEPS - 1);
        end else if (cmd.fold) begin
            lcg_value_reg <= fold_value;
            if (cmd.init_step) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
        if (cmd.mul) begin
            lcg_prod_reg  <= PROD_W'(lcg_value_reg * LCG_MULT);
            slot_prod_reg <= SPROD_W'(last_output_reg * RECIP);
        end
        if (cmd.draw_write) begin
            out_value_reg    <= rd_data_reg;
            out_near_one_reg <= rd_data_reg > NEAR_ONE_LIMIT;
        end
    end

    assign sts.last_zero = (last_output_reg == '0);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_near_one = out_near_one_reg;

endmodule

[sv/lcg_shuffle_random_generator.sv]
// ----------------------------------------------------------------------------
// lcg_shuffle_random_generator
// Minimal-standard multiplicative generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Each input word requests one 31-bit pseudo-random value (1 .. 2^31-2) with a
// near_one flag set above 2147483389. A normal draw registers the 16807
// product and the slot reciprocal product as the word is accepted, then does
// the modular fold and the table read, then swaps the table slot and loads the
// output register. The first request after reset, or one with reseed set, first
// initializes from the seed register: TABLE_DEPTH + 8 generator steps through
// the same multiply and fold, then the draw. The output register holds a result
// while the next word is accepted; a draw waits in its last cycle only if that
// register is still full. Write the seed only while the block is idle.
// ----------------------------------------------------------------------------
module lcg_shuffle_random_generator #(
    parameter int TABLE_DEPTH = lcg_shuf_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,  // seed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] reseed, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [30:0] value, [31] zero
    output logic        m_tuser       // [0] near_one
);
    import lcg_shuf_pkg::*;

    cmd_t               cmd;
    status_t            sts;
    logic [VALUE_W-1:0] out_value;

    lcg_shuf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_reseed (s_tdata[0]),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lcg_shuf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_value    (out_value),
        .out_near_one (m_tuser)
    );

    assign m_tdata = {1'b0, out_value};

endmodule
